/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by utf8_stream_decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");

`endif

/* rtl/u8sd_pkg.sv */
// ----------------------------------------------------------------------------
// u8sd_pkg
// Types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8sd_pkg;

	localparam int CP_W  = 21;
	localparam int CNT_W = 3;

	localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

	// Results of one input byte: cnt results, all U+FFFD but the last,
	// which is last_cp
	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [CP_W-1:0]  last_cp;
	} desc_t;

endpackage

`default_nettype wire

/* rtl/u8sd_decode.sv */
// ----------------------------------------------------------------------------
// u8sd_decode
// Sequence state and per-byte decode into a registered result descriptor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8sd_decode (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    data_byte,
	input  wire logic          final_byte,
	input  wire logic          take,
	output logic               desc_valid,
	output u8sd_pkg::desc_t    desc
);
	import u8sd_pkg::*;

	logic [1:0]      exp_q;
	logic [1:0]      rcv_q;
	logic [CP_W-1:0] part_q;

	logic            valid_s1;
	desc_t           desc_s1;

	logic            accept;
	logic            seq_open;
	logic            is_cont;
	logic            is_lead;
	logic [1:0]      rcv_inc;
	logic [CP_W-1:0] part_sh;
	logic [CNT_W-1:0] pre_cnt;
	logic            fresh_hit;
	logic [CP_W-1:0] fresh_cp;

	logic [1:0]      exp_d;
	logic [1:0]      rcv_d;
	logic [CP_W-1:0] part_d;
	desc_t           desc_d;

	assign accept   = in_valid && in_ready;
	assign in_ready = !valid_s1 || take;

	// Byte classification
	assign seq_open = (exp_q != 2'd0);
	assign is_cont  = (data_byte[7:6] == 2'b10);
	assign is_lead  = (data_byte[7:5] == 3'b110) || (data_byte[7:4] == 4'b1110) ||
		(data_byte[7:3] == 5'b11110);
	assign rcv_inc  = rcv_q + 2'd1;
	assign part_sh  = {part_q[CP_W-7:0], data_byte[5:0]};
	assign pre_cnt  = seq_open ? ({1'b0, rcv_q} + 3'd1) : 3'd0;

	// Next state and result descriptor
	always_comb begin
		exp_d     = exp_q;
		rcv_d     = rcv_q;
		part_d    = part_q;
		fresh_hit = 1'b0;
		fresh_cp  = REPLACEMENT_CP;
		desc_d    = '{cnt: '0, last_cp: REPLACEMENT_CP};
		if (seq_open && is_cont) begin
			if (rcv_inc >= exp_q) begin
				desc_d = '{cnt: 3'd1, last_cp: part_sh};
				exp_d  = 2'd0;
				rcv_d  = 2'd0;
				part_d = '0;
			end else if (final_byte) begin
				desc_d = '{cnt: 3'd1 + {1'b0, rcv_inc}, last_cp: REPLACEMENT_CP};
				exp_d  = 2'd0;
				rcv_d  = 2'd0;
				part_d = '0;
			end else begin
				rcv_d  = rcv_inc;
				part_d = part_sh;
			end
		end else begin
			// a broken sequence is closed, then the byte is decoded afresh
			exp_d  = 2'd0;
			rcv_d  = 2'd0;
			part_d = '0;
			if (!data_byte[7]) begin
				fresh_hit = 1'b1;
				fresh_cp  = {{(CP_W-8){1'b0}}, data_byte};
			end else if (is_lead) begin
				if (final_byte) begin
					fresh_hit = 1'b1;
				end else if (data_byte[7:5] == 3'b110) begin
					exp_d  = 2'd1;
					part_d = {{(CP_W-5){1'b0}}, data_byte[4:0]};
				end else if (data_byte[7:4] == 4'b1110) begin
					exp_d  = 2'd2;
					part_d = {{(CP_W-4){1'b0}}, data_byte[3:0]};
				end else begin
					exp_d  = 2'd3;
					part_d = {{(CP_W-3){1'b0}}, data_byte[2:0]};
				end
			end else begin
				fresh_hit = 1'b1;
			end
			desc_d = '{cnt: pre_cnt + {2'b00, fresh_hit}, last_cp: fresh_cp};
		end
	end

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q  <= 2'd0;
			rcv_q  <= 2'd0;
			part_q <= '0;
		end else if (accept) begin
			exp_q  <= exp_d;
			rcv_q  <= rcv_d;
			part_q <= part_d;
		end
	end

	// Descriptor register; bytes with no result leave it empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (desc_d.cnt != '0);
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc_d;
		end
	end

	assign desc_valid = valid_s1;
	assign desc       = desc_s1;

endmodule

`default_nettype wire

/* rtl/u8sd_emit.sv */
// ----------------------------------------------------------------------------
// u8sd_emit
// Output register that plays out the results of one descriptor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8sd_emit (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    desc_valid,
	input  wire u8sd_pkg::desc_t         desc,
	output logic                         take,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [u8sd_pkg::CP_W-1:0]    code_point,
	output logic                         run_end
);
	import u8sd_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [CP_W-1:0]  last_q;
	logic             last_one;

	assign last_one   = (cnt_q == 3'd1);
	assign out_valid  = (cnt_q != '0);
	assign take       = desc_valid && ((cnt_q == '0) || (last_one && out_ready));
	assign code_point = last_one ? last_q : REPLACEMENT_CP;
	assign run_end    = last_one;

	// Remaining result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			cnt_q <= desc.cnt;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			last_q <= desc.last_cp;
		end
	end

endmodule

`default_nettype wire

/* rtl/utf8_stream_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder: one byte in per item, code points out.
//
// Takes one byte per cycle. A byte that ends or breaks a sequence yields one
// to four code points, played out one per cycle from the output register
// while m_tready is high; the input stalls while a descriptor waits for it
// to empty or accept its last result. A descriptor register between
// decode and output lets the next byte enter while a result waits.
// No overlong, surrogate or range checks: values reach 0x1FFFFF.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module utf8_stream_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // final_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [20:0] code_point, [23:21] zero
	output logic             m_tlast    // run_end
);
	import u8sd_pkg::*;

	logic            desc_valid;
	desc_t           desc;
	logic            take;
	logic [CP_W-1:0] code_point;

	u8sd_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.data_byte  (s_tdata),
		.final_byte (s_tlast),
		.take       (take),
		.desc_valid (desc_valid),
		.desc       (desc)
	);

	u8sd_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc_valid),
		.desc       (desc),
		.take       (take),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.code_point (code_point),
		.run_end    (m_tlast)
	);

	assign m_tdata = {3'b000, code_point};

	// Checks
	`ASSERT_IMPLIES(a_desc_cnt, clk, arst_n, desc_valid, (desc.cnt != '0) && (desc.cnt <= 3'd4))
	`ASSERT_IMPLIES(a_lead_repl, clk, arst_n, m_tvalid && !m_tlast, code_point == REPLACEMENT_CP)
	`ASSERT_NEXT(a_run_cont, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for utf8_stream_decoder.
//
// Bytes go in on the slave stream, both as hand-picked cases and as random
// text. The text is mostly well-formed sequences, with some noise and some
// sequences cut short. A scoreboard decodes each accepted byte on its own
// and queues the code points that byte should cause. It then compares every
// item on the master stream against the oldest queued code point. The
// sender's gaps and the receiver's stalls vary from phase to phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import u8sd_pkg::*;

	// Byte class tags (top bits of a UTF-8 byte)
	localparam logic [1:0] CONT_TAG  = 2'b10;
	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;
	localparam logic [4:0] LEAD4_TAG = 5'b11110;

	localparam int SETTLE_CYCLES = 20;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            run_end;
	} cp_item_t;

	// Software decoder plus the queue of code points still owed by the block
	class decode_scoreboard;
		cp_item_t        expected_cps[$];
		logic [1:0]      open_need;
		logic [1:0]      open_got;
		logic [CP_W-1:0] payload;
		int              failures;

		function new();
			open_need = '0;
			open_got  = '0;
			payload   = '0;
			failures  = 0;
		endfunction

		function int pending();
			return expected_cps.size();
		endfunction

		// Decode one accepted byte and queue what it should produce
		function void note_byte(logic [7:0] b, logic fin);
			cp_item_t batch[$];
			cp_item_t one;
			bit       handled;
			handled = 1'b0;
			one.run_end = 1'b0;

			if (open_need != 0) begin
				if (b[7:6] == CONT_TAG) begin
					payload  = {payload[CP_W-7:0], b[5:0]};
					open_got = open_got + 2'd1;
					if (open_got >= open_need) begin
						one.cp = payload;
						batch = {batch, one};
						open_need = '0;
						open_got  = '0;
						payload   = '0;
					end else if (fin) begin
						// early end: lead plus every continuation taken
						one.cp = REPLACEMENT_CP;
						for (int i = 0; i <= open_got; i++)
							batch = {batch, one};
						open_need = '0;
						open_got  = '0;
						payload   = '0;
					end
					handled = 1'b1;
				end else begin
					// broken sequence: flush, then decode this byte afresh
					one.cp = REPLACEMENT_CP;
					for (int i = 0; i <= open_got; i++)
						batch = {batch, one};
					open_need = '0;
					open_got  = '0;
					payload   = '0;
				end
			end

			if (!handled) begin
				if (!b[7]) begin
					one.cp = {{(CP_W-8){1'b0}}, b};
					batch = {batch, one};
				end else if (b[7:5] == LEAD2_TAG || b[7:4] == LEAD3_TAG ||
						b[7:3] == LEAD4_TAG) begin
					if (fin) begin
						one.cp = REPLACEMENT_CP;
						batch = {batch, one};
					end else if (b[7:5] == LEAD2_TAG) begin
						open_need = 2'd1;
						open_got  = '0;
						payload   = {{(CP_W-5){1'b0}}, b[4:0]};
					end else if (b[7:4] == LEAD3_TAG) begin
						open_need = 2'd2;
						open_got  = '0;
						payload   = {{(CP_W-4){1'b0}}, b[3:0]};
					end else begin
						open_need = 2'd3;
						open_got  = '0;
						payload   = {{(CP_W-3){1'b0}}, b[2:0]};
					end
				end else begin
					// stray continuation or 0xF8..0xFF
					one.cp = REPLACEMENT_CP;
					batch = {batch, one};
				end
			end

			if (batch.size() > 0)
				batch[batch.size()-1].run_end = 1'b1;
			expected_cps = {expected_cps, batch};
		endfunction

		function void report(string msg);
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("[%0t] ERROR: %s", $time, msg);
		endfunction

		// Compare one output item with the oldest expectation
		function void check_code_point(logic [23:0] data, logic last);
			cp_item_t exp_item;
			if (expected_cps.size() == 0) begin
				report($sformatf("unexpected item: data=%06h last=%0b", data, last));
				return;
			end
			exp_item = expected_cps.pop_front();
			if (data !== {3'b000, exp_item.cp})
				report($sformatf("code point: expected %06h, got %06h",
					{3'b000, exp_item.cp}, data));
			if (last !== exp_item.run_end)
				report($sformatf("run_end on %06h: expected %0b, got %0b",
					exp_item.cp, exp_item.run_end, last));
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;

	int src_idle_pct  = 0;
	int sink_stall_pct = 0;

	decode_scoreboard sb;

	utf8_stream_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),    // [7:0] data_byte
		.s_tlast  (s_tlast),    // final_byte
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),    // [20:0] code_point, [23:21] zero
		.m_tlast  (m_tlast)     // run_end
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Hard stop if the run hangs
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Output side: check accepted items, then pick next cycle's ready
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_code_point(m_tdata, m_tlast);
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Present one byte, with a random gap first, and wait for acceptance
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_byte(b, fin);
	endtask

	// Hold the input idle until every owed code point has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random text: whole sequences, some cut short, some noise bytes
	task automatic send_random_text(input int n_items);
		int         sent;
		int         pick;
		int         len;
		bit         cut;
		logic       fin;
		logic [7:0] seq[4];
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			cut  = 1'b0;
			if (pick < 15) begin
				seq[0] = 8'($urandom);
				len = 1;
			end else begin
				len = $urandom_range(1, 4);
				case (len)
					1: seq[0] = {1'b0, 7'($urandom)};
					2: seq[0] = {LEAD2_TAG, 5'($urandom)};
					3: seq[0] = {LEAD3_TAG, 4'($urandom)};
					default: seq[0] = {LEAD4_TAG, 3'($urandom)};
				endcase
				for (int i = 1; i < len; i++)
					seq[i] = {CONT_TAG, 6'($urandom)};
				if (pick < 30 && len > 1) begin
					len = $urandom_range(1, len - 1);
					cut = 1'b1;
				end
			end
			for (int i = 0; i < len; i++) begin
				fin = ($urandom_range(15) == 0) ||
					(cut && i == len - 1 && $urandom_range(1) == 1);
				send_byte(seq[i], fin);
				sent++;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cases, no idling
		send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0);
		send_byte(8'hC2, 1'b0); send_byte(8'hA9, 1'b0);
		send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0);
		// largest value reachable: 0x1FFFFF
		send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
		// stray continuation, invalid byte
		send_byte(8'h80, 1'b0); send_byte(8'hFF, 1'b0);
		// sequence broken by plain ASCII
		send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'h41, 1'b0);
		// four-byte sequence broken after three bytes: four results at once
		send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0);
		send_byte(8'hBF, 1'b0); send_byte(8'hF8, 1'b0);
		// text ends inside a sequence
		send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'h80, 1'b1);
		// text ends on a lead byte, then on a plain byte
		send_byte(8'hC3, 1'b1); send_byte(8'h41, 1'b1);
		wait_drained();

		// Random phases with different gap and stall rates
		src_idle_pct = 0;  sink_stall_pct = 0;
		send_random_text(85);
		wait_drained();
		src_idle_pct = 62; sink_stall_pct = 0;
		send_random_text(85);
		wait_drained();
		src_idle_pct = 0;  sink_stall_pct = 62;
		send_random_text(85);
		wait_drained();
		src_idle_pct = 13; sink_stall_pct = 13;
		send_random_text(85);
		wait_drained();

		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
